@@ hw/rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CHECK_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tga_rle_pkg.sv @@
package tga_rle_pkg;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 8;
  localparam int TOTAL_W  = 32;
  localparam int BPP_W    = 3;
  localparam int SLOT_W   = 2;
  localparam int PART_W   = 24;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TOTAL     = 2'd2;

  // reset values of the registers
  localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;

  // packet header decode
  localparam logic [BYTE_W-1:0] RAW_LIMIT = 8'd128;
  localparam logic [BYTE_W-1:0] RUN_BIAS  = 8'd127;
  localparam logic [BYTE_W-1:0] FULL_BYTE = 8'd255;

  // last byte slot of a pixel, by pixel size
  localparam logic [SLOT_W-1:0] LAST_SLOT_GREY = 2'd0;
  localparam logic [SLOT_W-1:0] LAST_SLOT_RGB  = 2'd2;
  localparam logic [SLOT_W-1:0] LAST_SLOT_RGBA = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'b01,
    PH_PIXEL  = 2'b10
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0]  pixel_word;
    logic [COUNT_W-1:0] repeat_count;
    logic               image_done;
    logic               packet_clipped;
  } result_t;

endpackage

@@ hw/rtl/tga_rle_in_if.sv @@
interface tga_rle_in_if;
  logic                            valid;
  logic                            ready;
  logic [tga_rle_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

@@ hw/rtl/tga_rle_out_if.sv @@
interface tga_rle_out_if;
  logic                             valid;
  logic                             ready;
  logic [tga_rle_pkg::WORD_W-1:0]   pixel_word;
  logic [tga_rle_pkg::COUNT_W-1:0]  repeat_count;
  logic                             image_done;
  logic                             packet_clipped;

  modport source (output valid, output pixel_word, output repeat_count,
                  output image_done, output packet_clipped, input ready);
  modport sink   (input valid, input pixel_word, input repeat_count,
                  input image_done, input packet_clipped, output ready);
endinterface

@@ hw/rtl/tga_rle_cfg_if.sv @@
interface tga_rle_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tga_rle_pkg::CFG_IDX_W-1:0]  index;
  logic [tga_rle_pkg::TOTAL_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/tga_rle_pixel_decoder.sv @@
// channel  dir  payload                                              ready
// bytes    in   data_byte                                            low when skid full
// pixels   out  pixel_word, repeat_count, image_done, packet_clipped from consumer
// cfg      in   index, data (bytes_per_pixel, rle_mode, pixel_total) always high
//
// one byte is taken every cycle while the skid entry is empty; a completed pixel
// is registered in the result register, or in the skid entry while that is held.
// decode state and the result register bracket a single combinational pass.
// the output holds a result register plus a one-entry skid, so bytes keep
// flowing while one result waits; input stalls only with both entries full.
// rst (synchronous) clears control state; no image is in progress after it.
`include "assert_macros.svh"

module tga_rle_pixel_decoder (
  input  logic          clk,
  input  logic          rst,
  tga_rle_in_if.sink    bytes,
  tga_rle_out_if.source pixels,
  tga_rle_cfg_if.sink   cfg
);

  logic [tga_rle_pkg::BPP_W-1:0]   bytes_per_pixel;
  logic                            rle_mode;
  logic [tga_rle_pkg::TOTAL_W-1:0] pixel_total;

  tga_rle_pkg::phase_t              phase, phase_next;
  logic [tga_rle_pkg::COUNT_W-1:0]  packet_left, packet_left_next;
  logic                             packet_is_run, packet_is_run_next;
  logic [tga_rle_pkg::SLOT_W-1:0]   byte_slot, byte_slot_next;
  logic [tga_rle_pkg::PART_W-1:0]   partial_pixel, partial_pixel_next;
  logic [tga_rle_pkg::TOTAL_W-1:0]  pixels_left, pixels_left_next;

  tga_rle_pkg::result_t res;
  logic                 res_valid;
  tga_rle_pkg::result_t out_data, skid_data;
  logic                 out_valid, skid_valid;

  logic accept, push, pop;

  logic [tga_rle_pkg::BYTE_W-1:0]   b;
  logic [tga_rle_pkg::TOTAL_W-1:0]  pl_eff, pl_minus_one, pl_minus_count;
  logic [tga_rle_pkg::SLOT_W-1:0]   last_slot;
  logic                             complete;
  logic [tga_rle_pkg::WORD_W-1:0]   word;
  logic [tga_rle_pkg::COUNT_W-1:0]  count, raw_left;
  logic                             run_clip;

  assign bytes.ready = !skid_valid;
  assign cfg.ready   = 1'b1;
  assign accept      = bytes.valid && bytes.ready;
  assign push        = accept && res_valid;
  assign pop         = out_valid && pixels.ready;

  assign pixels.valid          = out_valid;
  assign pixels.pixel_word     = out_data.pixel_word;
  assign pixels.repeat_count   = out_data.repeat_count;
  assign pixels.image_done     = out_data.image_done;
  assign pixels.packet_clipped = out_data.packet_clipped;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= tga_rle_pkg::BPP_RESET;
      rle_mode        <= 1'b0;
      pixel_total     <= tga_rle_pkg::TOTAL_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        tga_rle_pkg::REG_BYTES_PER_PIXEL:
          bytes_per_pixel <= cfg.data[tga_rle_pkg::BPP_W-1:0];
        tga_rle_pkg::REG_RLE_MODE:
          rle_mode <= cfg.data[0];
        tga_rle_pkg::REG_PIXEL_TOTAL:
          pixel_total <= cfg.data;
        default: ;
      endcase
    end
  end

  // decode pass for one byte
  always_comb begin
    b = bytes.data_byte;

    // an idle decoder loads the image size on its first byte
    if (pixels_left == '0) begin
      pl_eff = (pixel_total == '0) ? tga_rle_pkg::TOTAL_RESET : pixel_total;
    end else begin
      pl_eff = pixels_left;
    end
    pl_minus_one = pl_eff - tga_rle_pkg::TOTAL_W'(1);

    priority if (bytes_per_pixel <= 3'd1) begin
      last_slot = tga_rle_pkg::LAST_SLOT_GREY;
    end else if (bytes_per_pixel <= 3'd3) begin
      last_slot = tga_rle_pkg::LAST_SLOT_RGB;
    end else begin
      last_slot = tga_rle_pkg::LAST_SLOT_RGBA;
    end
    complete = byte_slot >= last_slot;

    unique case (byte_slot)
      2'd0: word = {24'd0, b};
      2'd1: word = {16'd0, b, partial_pixel[7:0]};
      2'd2: word = {8'd0, b, partial_pixel[15:0]};
      2'd3: word = {b, partial_pixel[23:0]};
    endcase
    if (last_slot == tga_rle_pkg::LAST_SLOT_GREY) begin
      word = {4{b}};
    end else if (last_slot == tga_rle_pkg::LAST_SLOT_RGB) begin
      word[31:24] = tga_rle_pkg::FULL_BYTE;
    end

    count          = (packet_left == '0) ? tga_rle_pkg::COUNT_W'(1) : packet_left;
    raw_left       = count - tga_rle_pkg::COUNT_W'(1);
    run_clip       = {24'd0, count} > pl_eff;
    pl_minus_count = pl_eff - {24'd0, count};

    phase_next         = phase;
    packet_left_next   = packet_left;
    packet_is_run_next = packet_is_run;
    pixels_left_next   = pl_eff;
    res_valid          = 1'b0;
    res.pixel_word     = word;
    res.repeat_count   = tga_rle_pkg::COUNT_W'(1);
    res.packet_clipped = 1'b0;

    if (!rle_mode) begin
      phase_next         = tga_rle_pkg::PH_HEADER;
      packet_left_next   = '0;
      packet_is_run_next = 1'b0;
      if (complete) begin
        res_valid        = 1'b1;
        pixels_left_next = pl_minus_one;
      end
    end else if (phase != tga_rle_pkg::PH_PIXEL) begin
      phase_next         = tga_rle_pkg::PH_PIXEL;
      packet_is_run_next = !(b < tga_rle_pkg::RAW_LIMIT);
      if (b < tga_rle_pkg::RAW_LIMIT) begin
        packet_left_next = b + tga_rle_pkg::COUNT_W'(1);
      end else begin
        packet_left_next = b - tga_rle_pkg::RUN_BIAS;
      end
    end else if (complete) begin
      res_valid = 1'b1;
      if (packet_is_run) begin
        // run is cut to what is left of the image
        if (run_clip) begin
          res.repeat_count   = pl_eff[tga_rle_pkg::COUNT_W-1:0];
          res.packet_clipped = 1'b1;
          pixels_left_next   = '0;
        end else begin
          res.repeat_count   = count;
          pixels_left_next   = pl_minus_count;
        end
        packet_left_next = '0;
        phase_next       = tga_rle_pkg::PH_HEADER;
      end else begin
        pixels_left_next   = pl_minus_one;
        packet_left_next   = raw_left;
        res.packet_clipped = (pl_minus_one == '0) && (raw_left != '0);
        if (raw_left == '0) begin
          phase_next = tga_rle_pkg::PH_HEADER;
        end
      end
    end

    // byte gathering
    byte_slot_next     = byte_slot;
    partial_pixel_next = partial_pixel;
    if ((rle_mode && phase != tga_rle_pkg::PH_PIXEL) || complete) begin
      byte_slot_next     = '0;
      partial_pixel_next = '0;
    end else begin
      byte_slot_next = byte_slot + tga_rle_pkg::SLOT_W'(1);
      case (byte_slot)
        2'd0:    partial_pixel_next = partial_pixel | {16'd0, b};
        2'd1:    partial_pixel_next = partial_pixel | {8'd0, b, 8'd0};
        2'd2:    partial_pixel_next = partial_pixel | {b, 16'd0};
        default: partial_pixel_next = partial_pixel;
      endcase
    end

    res.image_done = pixels_left_next == '0;
    if (res_valid && res.image_done) begin
      phase_next         = tga_rle_pkg::PH_HEADER;
      packet_left_next   = '0;
      packet_is_run_next = 1'b0;
      byte_slot_next     = '0;
      partial_pixel_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tga_rle_pkg::PH_HEADER;
      packet_left   <= '0;
      packet_is_run <= 1'b0;
      byte_slot     <= '0;
      partial_pixel <= '0;
      pixels_left   <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      packet_left   <= packet_left_next;
      packet_is_run <= packet_is_run_next;
      byte_slot     <= byte_slot_next;
      partial_pixel <= partial_pixel_next;
      pixels_left   <= pixels_left_next;
    end
  end

  // result register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : res;
    end
    if (out_valid && !pop && push) begin
      skid_data <= res;
    end
  end

  `CHECK_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid entry without result")
  `CHECK_SAME(a_repeat_nonzero, clk, rst, out_valid, pixels.repeat_count != '0, "zero repeat")
  `CHECK_NEXT(a_done_clears, clk, rst, push && res.image_done, pixels_left == '0, "image not closed")
  `CHECK_NEXT(a_plain_header, clk, rst, accept && !rle_mode, phase == tga_rle_pkg::PH_HEADER, "plain mode left packet phase set")

endmodule

@@ tb/tb.sv @@
module tb;

  // tracks the decoder: config, packet and pixel state, and the pixels still owed
  class pixel_ledger;
    logic [tga_rle_pkg::BPP_W-1:0]   bpp;
    logic                            rle;
    logic [tga_rle_pkg::TOTAL_W-1:0] total;
    tga_rle_pkg::phase_t             phase;
    logic [tga_rle_pkg::COUNT_W-1:0] pkt_left;
    logic                            pkt_run;
    logic [tga_rle_pkg::SLOT_W-1:0]  slot;
    logic [tga_rle_pkg::PART_W-1:0]  partial;
    logic [tga_rle_pkg::TOTAL_W-1:0] pix_left;
    tga_rle_pkg::result_t            pending_pixels[$];
    int                              bytes_in;
    int                              checked;
    int                              images;
    int                              clips;
    int                              errors;

    function new();
      bpp = tga_rle_pkg::BPP_RESET;
      rle = 1'b0;
      total = tga_rle_pkg::TOTAL_RESET;
      phase = tga_rle_pkg::PH_HEADER;
      pkt_left = '0;
      pkt_run = 1'b0;
      slot = '0;
      partial = '0;
      pix_left = '0;
      bytes_in = 0;
      checked = 0;
      images = 0;
      clips = 0;
      errors = 0;
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function logic [2:0] pixel_bytes();
      if (bpp <= 3'd1) return 3'd1;
      if (bpp <= 3'd3) return 3'd3;
      return 3'd4;
    endfunction

    function void set_reg(logic [tga_rle_pkg::CFG_IDX_W-1:0] idx,
                          logic [tga_rle_pkg::TOTAL_W-1:0] value);
      case (idx)
        tga_rle_pkg::REG_BYTES_PER_PIXEL: bpp = value[tga_rle_pkg::BPP_W-1:0];
        tga_rle_pkg::REG_RLE_MODE: rle = value[0];
        tga_rle_pkg::REG_PIXEL_TOTAL: total = value;
        default: ;
      endcase
    endfunction

    // adds a byte at the current slot; a pixel closes once slot reaches size-1
    function bit gather_byte(logic [tga_rle_pkg::BYTE_W-1:0] b,
                             output logic [tga_rle_pkg::WORD_W-1:0] word);
      logic [2:0]                     size;
      logic [tga_rle_pkg::WORD_W-1:0] low_mask;
      logic [tga_rle_pkg::WORD_W-1:0] shifted;
      size = pixel_bytes();
      shifted = {24'b0, b} << (8 * slot);
      word = '0;
      if ({1'b0, slot} + 3'd1 >= size) begin
        if (size == 3'd1) begin
          word = {4{b}};
        end else begin
          low_mask = (slot == 2'd0) ? 32'd0 : ((32'd1 << (8 * slot)) - 32'd1);
          word = ({8'b0, partial} & low_mask) | shifted;
          if (size == 3'd3) word[31:24] = tga_rle_pkg::FULL_BYTE;
        end
        slot = '0;
        partial = '0;
        return 1'b1;
      end
      partial = partial | shifted[tga_rle_pkg::PART_W-1:0];
      slot = slot + 2'd1;
      return 1'b0;
    endfunction

    function void take_byte(logic [tga_rle_pkg::BYTE_W-1:0] b);
      logic [tga_rle_pkg::WORD_W-1:0]  word;
      logic [tga_rle_pkg::COUNT_W-1:0] count;
      logic [tga_rle_pkg::TOTAL_W-1:0] rep;
      logic                            clip;
      tga_rle_pkg::result_t            r;
      bytes_in++;
      rep = 32'd1;
      clip = 1'b0;
      if (pix_left == 0) pix_left = (total == 0) ? 32'd1 : total;
      if (!rle) begin
        phase = tga_rle_pkg::PH_HEADER;
        pkt_left = '0;
        pkt_run = 1'b0;
        if (!gather_byte(b, word)) return;
        pix_left = pix_left - 32'd1;
      end else if (phase != tga_rle_pkg::PH_PIXEL) begin
        slot = '0;
        partial = '0;
        if (b < tga_rle_pkg::RAW_LIMIT) begin
          pkt_run = 1'b0;
          pkt_left = b + 8'd1;
        end else begin
          pkt_run = 1'b1;
          pkt_left = b - tga_rle_pkg::RUN_BIAS;
        end
        phase = tga_rle_pkg::PH_PIXEL;
        return;
      end else begin
        count = (pkt_left == 0) ? 8'd1 : pkt_left;
        if (!gather_byte(b, word)) return;
        if (pkt_run) begin
          if ({24'b0, count} > pix_left) begin
            rep = pix_left;
            clip = 1'b1;
          end else begin
            rep = {24'b0, count};
          end
          pix_left = pix_left - rep;
          pkt_left = '0;
          phase = tga_rle_pkg::PH_HEADER;
        end else begin
          pix_left = pix_left - 32'd1;
          pkt_left = count - 8'd1;
          if (pix_left == 0 && pkt_left != 0) clip = 1'b1;
          if (pkt_left == 0) phase = tga_rle_pkg::PH_HEADER;
        end
      end
      r.pixel_word = word;
      r.repeat_count = rep[tga_rle_pkg::COUNT_W-1:0];
      r.image_done = (pix_left == 0);
      r.packet_clipped = clip;
      pending_pixels.push_back(r);
      if (pix_left == 0) begin
        phase = tga_rle_pkg::PH_HEADER;
        pkt_left = '0;
        pkt_run = 1'b0;
        slot = '0;
        partial = '0;
      end
    endfunction

    function void match_pixel(tga_rle_pkg::result_t got);
      tga_rle_pkg::result_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel with nothing expected: expected none, got word %h repeat %0d",
                 $time, got.pixel_word, got.repeat_count);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      checked++;
      if (want.image_done) images++;
      if (want.packet_clipped) clips++;
      if (got.pixel_word !== want.pixel_word) begin
        $display("%0t: pixel_word expected %h got %h", $time, want.pixel_word, got.pixel_word);
        errors++;
      end
      if (got.repeat_count !== want.repeat_count) begin
        $display("%0t: repeat_count expected %0d got %0d", $time, want.repeat_count,
                 got.repeat_count);
        errors++;
      end
      if (got.image_done !== want.image_done) begin
        $display("%0t: image_done expected %b got %b", $time, want.image_done,
                 got.image_done);
        errors++;
      end
      if (got.packet_clipped !== want.packet_clipped) begin
        $display("%0t: packet_clipped expected %b got %b", $time, want.packet_clipped,
                 got.packet_clipped);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady = 1'b0;
  int   hold_request = 0;

  pixel_ledger ledger = new();

  tga_rle_in_if  bytes_if ();
  tga_rle_out_if pixels_if ();
  tga_rle_cfg_if cfg_if ();

  tga_rle_pixel_decoder uut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if),
    .pixels (pixels_if),
    .cfg    (cfg_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  initial begin : pixel_sink
    int span;
    pixels_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        // long hold-off so the skid fills and byte requests back up
        span = hold_request;
        hold_request = 0;
        pixels_if.ready <= 1'b0;
        repeat (span) @(negedge clk);
        pixels_if.ready <= 1'b1;
      end else begin
        span = pick_gap();
        if (span > 0) begin
          pixels_if.ready <= 1'b0;
          repeat (span) @(negedge clk);
        end
        pixels_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : pixel_watch
    tga_rle_pkg::result_t got;
    if (!rst && pixels_if.valid && pixels_if.ready) begin
      got.pixel_word = pixels_if.pixel_word;
      got.repeat_count = pixels_if.repeat_count;
      got.image_done = pixels_if.image_done;
      got.packet_clipped = pixels_if.packet_clipped;
      ledger.match_pixel(got);
    end
  end

  task automatic send_byte(input logic [tga_rle_pkg::BYTE_W-1:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      bytes_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bytes_if.valid <= 1'b1;
    bytes_if.data_byte <= b;
    do @(posedge clk); while (!bytes_if.ready);
    ledger.take_byte(b);
  endtask

  // stop offering bytes and wait out every owed pixel plus the pipeline
  task automatic drain_pixels();
    @(negedge clk);
    bytes_if.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [tga_rle_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tga_rle_pkg::TOTAL_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    ledger.set_reg(idx, value);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_bytes(input logic [tga_rle_pkg::BYTE_W-1:0] list[$]);
    foreach (list[i]) send_byte(list[i]);
  endtask

  // feed bytes until the image in progress is finished
  task automatic close_image();
    while (ledger.pix_left != 0)
      send_byte((ledger.rle && ledger.phase == tga_rle_pkg::PH_HEADER) ? 8'hFF :
                tga_rle_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // one image of well-formed content; now and then a packet overruns the image
  task automatic send_image();
    logic [tga_rle_pkg::TOTAL_W-1:0] left;
    int                              n;
    int                              size;
    bit                              run;
    size = int'(ledger.pixel_bytes());
    left = (ledger.total == 0) ? 32'd1 : ledger.total;
    if (!ledger.rle) begin
      repeat (left * size) send_byte(tga_rle_pkg::BYTE_W'($urandom_range(0, 255)));
      return;
    end
    while (left != 0) begin
      run = 1'($urandom_range(0, 1));
      if (run) n = $urandom_range(1, (left > 128) ? 128 : left);
      else n = $urandom_range(1, (left > 12) ? 12 : left);
      if ($urandom_range(0, 9) == 0) n = left + $urandom_range(1, run ? 20 : 3);
      if (n > 128) n = 128;
      send_byte(tga_rle_pkg::BYTE_W'(run ? n + 127 : n - 1));
      repeat (run ? size : n * size) send_byte(tga_rle_pkg::BYTE_W'($urandom_range(0, 255)));
      left = (n >= left) ? 32'd0 : left - n;
    end
  endtask

  initial begin : stimulus
    logic [tga_rle_pkg::BPP_W-1:0]   bpp_pick;
    logic                            rle_pick;
    logic [tga_rle_pkg::TOTAL_W-1:0] total_pick;
    int                              r;
    rst = 1'b1;
    bytes_if.valid = 1'b0;
    bytes_if.data_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = tga_rle_pkg::REG_BYTES_PER_PIXEL;
    cfg_if.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset config: plain rgba, single-pixel image
    send_bytes('{8'h00, 8'hFF, 8'h80, 8'h7F});
    drain_pixels();
    // grey replication
    cfg_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd1);
    cfg_write(tga_rle_pkg::REG_PIXEL_TOTAL, 32'd3);
    send_bytes('{8'hFF, 8'h00, 8'h5A});
    drain_pixels();
    // rgb packets: raw of one, then a full run cut to what is left
    cfg_write(tga_rle_pkg::REG_RLE_MODE, 32'd1);
    cfg_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd3);
    cfg_write(tga_rle_pkg::REG_PIXEL_TOTAL, 32'd5);
    send_bytes('{8'h00, 8'h12, 8'h34, 8'h56, 8'hFF, 8'hA5, 8'h5A, 8'hC3});
    drain_pixels();
    // raw packet overruns the image, the leftover bytes start the next one
    cfg_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd1);
    cfg_write(tga_rle_pkg::REG_PIXEL_TOTAL, 32'd2);
    send_bytes('{8'h7F, 8'hA1, 8'hA2, 8'h80, 8'hC3});
    drain_pixels();
    // pixel size shrinks in the middle of a pixel, zero total
    cfg_write(tga_rle_pkg::REG_RLE_MODE, 32'd0);
    cfg_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd7);
    cfg_write(tga_rle_pkg::REG_PIXEL_TOTAL, 32'd0);
    send_bytes('{8'h10, 8'h20});
    drain_pixels();
    cfg_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd2);
    send_byte(8'h30);
    drain_pixels();
    cfg_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd5);
    send_bytes('{8'h01, 8'h02, 8'h03});
    drain_pixels();
    cfg_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd3);
    send_byte(8'h04);
    drain_pixels();

    // back-pressure: sink holds off while grey bytes keep coming
    cfg_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd1);
    cfg_write(tga_rle_pkg::REG_PIXEL_TOTAL, 32'd40);
    close_image();
    steady = 1'b1;
    hold_request = 80;
    send_image();
    steady = 1'b0;

    while (ledger.bytes_in < 360) begin
      drain_pixels();
      case ($urandom_range(0, 2))
        0: bpp_pick = 3'd1;
        1: bpp_pick = 3'd3;
        default: bpp_pick = 3'd4;
      endcase
      if ($urandom_range(0, 4) == 0) bpp_pick = tga_rle_pkg::BPP_W'($urandom_range(0, 7));
      rle_pick = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 19);
      if (r == 0) begin
        total_pick = 32'd0;
      end else if (r == 1) begin
        total_pick = $urandom_range(128, 300);
        rle_pick = 1'b1;
      end else if (r < 7) begin
        total_pick = $urandom_range(13, 60);
      end else begin
        total_pick = $urandom_range(1, 12);
      end
      cfg_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, tga_rle_pkg::TOTAL_W'(bpp_pick));
      cfg_write(tga_rle_pkg::REG_RLE_MODE, tga_rle_pkg::TOTAL_W'(rle_pick));
      cfg_write(tga_rle_pkg::REG_PIXEL_TOTAL, total_pick);
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(5, 20)) send_byte(tga_rle_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          close_image();
          send_image();
        end
      end
    end
    steady = 1'b0;

    // full-range total: long runs never reach the end of the image
    drain_pixels();
    cfg_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'd4);
    cfg_write(tga_rle_pkg::REG_RLE_MODE, 32'd1);
    cfg_write(tga_rle_pkg::REG_PIXEL_TOTAL, 32'hFFFF_FFFF);
    close_image();
    repeat (10) begin
      send_byte(8'hFF);
      repeat (4) send_byte(tga_rle_pkg::BYTE_W'($urandom_range(0, 255)));
    end
    drain_pixels();

    $display("tb: %0d bytes in, %0d pixel results checked, %0d images closed, %0d clipped",
             ledger.bytes_in, ledger.checked, ledger.images, ledger.clips);
    $display("tb: grey/rgb/rgba plain and rle, odd sizes, mid-pixel size change, back-pressure");
    if (ledger.errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
